// ===== rtl/rrs_pkg.sv =====
// Shared constants and types of the round-robin sleep scheduler.
package rrs_pkg;

  localparam int SLOTS     = 16;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;
  localparam int CHOSEN_W  = 4;
  localparam int STATUS_W  = 2;
  localparam int SSTAT_W   = 2;

  localparam logic [OP_W-1:0] OP_PICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADMIT = 2'd1;
  localparam logic [OP_W-1:0] OP_SLEEP = 2'd2;
  localparam logic [OP_W-1:0] OP_EXIT  = 2'd3;

  localparam logic [SSTAT_W-1:0] SS_UNUSED   = 2'd0;
  localparam logic [SSTAT_W-1:0] SS_READY    = 2'd1;
  localparam logic [SSTAT_W-1:0] SS_RUNNING  = 2'd2;
  localparam logic [SSTAT_W-1:0] SS_SLEEPING = 2'd3;

  localparam logic [STATUS_W-1:0] RS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] RS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] RS_HALT    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXIT_CHK,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/rrs_if.sv =====
// Valid/ready channel interfaces for the scheduler's request and result words.
interface rrs_in_if;
  logic                          valid;
  logic                          ready;
  logic [rrs_pkg::OP_W-1:0]      op;
  logic [rrs_pkg::SLOT_W-1:0]    slot;
  logic [rrs_pkg::TIME_W-1:0]    now;
  logic [rrs_pkg::TIME_W-1:0]    duration;

  modport source (output valid, op, slot, now, duration, input ready);
  modport sink (input valid, op, slot, now, duration, output ready);
endinterface

interface rrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [rrs_pkg::CHOSEN_W-1:0]  chosen_slot;
  logic [rrs_pkg::STATUS_W-1:0]  status;

  modport source (output valid, chosen_slot, status, input ready);
  modport sink (input valid, chosen_slot, status, output ready);
endinterface

// ===== rtl/round_robin_sleep_scheduler.sv =====
// Top level of the round-robin sleep scheduler with its slot memories and sequencer.
//
// The block takes one request word at a time and returns one result word per request.
// Slot status, user-mode marks and wake times live in synchronous memories with one read
// port and one write port and a registered read. A scan issues one read per slot visited
// and checks each entry in the cycle after. A sleep goes from ST_IDLE to ST_FIN, and an
// exit in kernel mode from ST_IDLE through ST_EXIT_CHK to ST_FIN; ST_FIN then moves the
// result into the output register. A pick visits 1 to SLOTS slots before its scan stops,
// all SLOTS of them when nothing is ready. An admit visits at most SLOTS - 1 slots. An
// exit in user mode first reads the user-mode mark of the current slot in ST_EXIT_CHK,
// then scans like a pick. A finished result waits while the output register is still
// full. The next request word is accepted from the cycle after the result moves to the
// output register, even while that result still waits there.
module round_robin_sleep_scheduler (
  input  logic      clk,
  input  logic      rst_n,
  rrs_in_if.sink    in_ch,
  rrs_out_if.source out_ch
);

  rrs_pkg::state_t state_r, state_nxt;

  logic [rrs_pkg::SSTAT_W-1:0] stat_mem [rrs_pkg::SLOTS];
  logic                        usr_mem  [rrs_pkg::SLOTS];
  logic [rrs_pkg::TIME_W-1:0]  wake_mem [rrs_pkg::SLOTS];

  logic [rrs_pkg::SLOTS-1:0]   stat_vld_r, usr_vld_r;

  logic [rrs_pkg::IDX_W-1:0]   rd_addr, rd_addr_r, wr_addr;
  logic [rrs_pkg::SSTAT_W-1:0] stat_rd_r, stat_wd;
  logic                        usr_rd_r, usr_wd;
  logic [rrs_pkg::TIME_W-1:0]  wake_rd_r, wake_wd;
  logic                        stat_vld_rd_r, usr_vld_rd_r;
  logic                        stat_we, usr_we, wake_we;

  logic [rrs_pkg::IDX_W-1:0]   cur_r, cur_nxt;
  logic [rrs_pkg::IDX_W-1:0]   pos_r, pos_nxt;
  logic [rrs_pkg::CNT_W-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic                        rd_live_r, rd_live_nxt;
  logic                        admit_r, admit_nxt;
  logic [rrs_pkg::TIME_W-1:0]  now_r, now_nxt;
  logic [rrs_pkg::IDX_W-1:0]   res_chosen_r, res_chosen_nxt;
  logic [rrs_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [rrs_pkg::CHOSEN_W-1:0] out_chosen_r, out_chosen_nxt;
  logic [rrs_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                        in_fire;
  logic [rrs_pkg::IDX_W:0]     cur_inc;
  logic [rrs_pkg::IDX_W-1:0]   scan_start;
  logic [rrs_pkg::IDX_W-1:0]   scan_addr;
  logic [rrs_pkg::CNT_W-1:0]   scan_limit;
  logic [rrs_pkg::SSTAT_W-1:0] eff_stat;
  logic                        eff_usr;
  logic                        hit;
  logic                        slot_ok;

  assign in_ch.ready        = (state_r == rrs_pkg::ST_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.chosen_slot = out_chosen_r;
  assign out_ch.status      = out_status_r;

  assign cur_inc    = {1'b0, cur_r} + 1'b1;
  assign scan_start = (32'(cur_inc) >= 32'(rrs_pkg::SLOTS)) ? rrs_pkg::IDX_W'(1)
                                                             : cur_inc[rrs_pkg::IDX_W-1:0];
  assign scan_addr  = (pos_r == '0) ? rrs_pkg::IDX_W'(1) : pos_r;
  assign scan_limit = admit_r ? rrs_pkg::CNT_W'(rrs_pkg::SLOTS - 1)
                              : rrs_pkg::CNT_W'(rrs_pkg::SLOTS);
  assign slot_ok    = (32'(in_ch.slot) < 32'(rrs_pkg::SLOTS));

  assign eff_stat = stat_vld_rd_r ? stat_rd_r
                  : ((rd_addr_r == '0) ? rrs_pkg::SS_RUNNING : rrs_pkg::SS_UNUSED);
  assign eff_usr  = usr_vld_rd_r && usr_rd_r;
  assign hit = admit_r ? (eff_stat == rrs_pkg::SS_UNUSED)
             : ((eff_stat == rrs_pkg::SS_READY) ||
                ((eff_stat == rrs_pkg::SS_SLEEPING) && (wake_rd_r <= now_r)));

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[wr_addr] <= stat_wd;
    end
    if (usr_we) begin
      usr_mem[wr_addr] <= usr_wd;
    end
    if (wake_we) begin
      wake_mem[wr_addr] <= wake_wd;
    end
    stat_rd_r <= stat_mem[rd_addr];
    usr_rd_r  <= usr_mem[rd_addr];
    wake_rd_r <= wake_mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_vld_r    <= '0;
      usr_vld_r     <= '0;
      stat_vld_rd_r <= 1'b0;
      usr_vld_rd_r  <= 1'b0;
    end else begin
      stat_vld_rd_r <= stat_vld_r[rd_addr];
      usr_vld_rd_r  <= usr_vld_r[rd_addr];
      if (stat_we) begin
        stat_vld_r[wr_addr] <= 1'b1;
      end
      if (usr_we) begin
        usr_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrs_pkg::ST_IDLE;
      cur_r       <= '0;
      rd_live_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      rd_live_r   <= rd_live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    issue_cnt_r  <= issue_cnt_nxt;
    admit_r      <= admit_nxt;
    now_r        <= now_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_status_r <= res_status_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    issue_cnt_nxt  = issue_cnt_r;
    rd_live_nxt    = 1'b0;
    admit_nxt      = admit_r;
    now_nxt        = now_r;
    res_chosen_nxt = res_chosen_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_chosen_nxt = out_chosen_r;
    out_status_nxt = out_status_r;
    rd_addr        = cur_r;
    wr_addr        = cur_r;
    stat_we        = 1'b0;
    usr_we         = 1'b0;
    wake_we        = 1'b0;
    stat_wd        = rrs_pkg::SS_UNUSED;
    usr_wd         = 1'b1;
    wake_wd        = in_ch.now + in_ch.duration;

    case (state_r)
      rrs_pkg::ST_IDLE: begin
        if (in_fire) begin
          now_nxt       = in_ch.now;
          pos_nxt       = scan_start;
          issue_cnt_nxt = '0;
          admit_nxt     = 1'b0;
          case (in_ch.op)
            rrs_pkg::OP_PICK: begin
              state_nxt = rrs_pkg::ST_SCAN;
            end
            rrs_pkg::OP_ADMIT: begin
              pos_nxt   = rrs_pkg::IDX_W'(1);
              admit_nxt = 1'b1;
              state_nxt = rrs_pkg::ST_SCAN;
            end
            rrs_pkg::OP_SLEEP: begin
              wr_addr        = rrs_pkg::IDX_W'(in_ch.slot);
              stat_we        = slot_ok;
              wake_we        = slot_ok;
              stat_wd        = rrs_pkg::SS_SLEEPING;
              res_chosen_nxt = cur_r;
              res_status_nxt = rrs_pkg::RS_OK;
              state_nxt      = rrs_pkg::ST_FIN;
            end
            default: begin
              state_nxt = rrs_pkg::ST_EXIT_CHK;
            end
          endcase
        end
      end

      rrs_pkg::ST_EXIT_CHK: begin
        if (eff_usr) begin
          stat_we   = 1'b1;
          stat_wd   = rrs_pkg::SS_UNUSED;
          state_nxt = rrs_pkg::ST_SCAN;
        end else begin
          res_chosen_nxt = cur_r;
          res_status_nxt = rrs_pkg::RS_HALT;
          state_nxt      = rrs_pkg::ST_FIN;
        end
      end

      rrs_pkg::ST_SCAN: begin
        if (rd_live_r && hit) begin
          wr_addr        = rd_addr_r;
          stat_we        = 1'b1;
          res_chosen_nxt = rd_addr_r;
          res_status_nxt = rrs_pkg::RS_OK;
          state_nxt      = rrs_pkg::ST_FIN;
          if (admit_r) begin
            stat_wd = rrs_pkg::SS_READY;
            usr_we  = 1'b1;
          end else begin
            stat_wd = rrs_pkg::SS_RUNNING;
            cur_nxt = rd_addr_r;
          end
        end else if (issue_cnt_r == scan_limit) begin
          res_chosen_nxt = '0;
          res_status_nxt = admit_r ? rrs_pkg::RS_NO_FREE : rrs_pkg::RS_OK;
          state_nxt      = rrs_pkg::ST_FIN;
        end else begin
          rd_addr       = scan_addr;
          rd_live_nxt   = 1'b1;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          pos_nxt       = (32'(pos_r) == rrs_pkg::SLOTS - 1) ? '0 : pos_r + 1'b1;
        end
      end

      rrs_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_chosen_nxt = rrs_pkg::CHOSEN_W'(res_chosen_r);
          out_status_nxt = res_status_r;
          state_nxt      = rrs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rrs_checker.sv =====
// Port-level checker for the round-robin sleep scheduler and its bind.
module rrs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rrs_pkg::CHOSEN_W-1:0]  out_chosen_slot,
  input logic [rrs_pkg::STATUS_W-1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen_slot) && $stable(out_status))
    else $error("Stalled result word changed or was dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A request word was taken while another was in progress.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == rrs_pkg::RS_OK) || (out_status == rrs_pkg::RS_NO_FREE) ||
                  (out_status == rrs_pkg::RS_HALT))
    else $error("Result word carries an undefined status.");

  a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == rrs_pkg::RS_NO_FREE) |-> (out_chosen_slot == '0))
    else $error("Failed admit reported a nonzero slot.");

endmodule

bind round_robin_sleep_scheduler rrs_checker u_rrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_chosen_slot (out_ch.chosen_slot),
  .out_status      (out_ch.status)
);

// ===== verif/round_robin_sleep_scheduler_tb.sv =====
// Self-checking testbench of the round-robin sleep scheduler with its own slot-table predictor.
module round_robin_sleep_scheduler_tb;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [rrs_pkg::CHOSEN_W-1:0] chosen;
    logic [rrs_pkg::STATUS_W-1:0] status;
  } grant_t;

  logic clk;
  logic rst_n;

  rrs_in_if  in_ch();
  rrs_out_if out_ch();

  round_robin_sleep_scheduler i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [rrs_pkg::SSTAT_W-1:0] sched_status [rrs_pkg::SLOTS];
  logic [rrs_pkg::TIME_W-1:0]  sched_wake   [rrs_pkg::SLOTS];
  logic                        sched_user   [rrs_pkg::SLOTS];
  logic [rrs_pkg::IDX_W-1:0]   sched_cur;

  grant_t grant_q[$];

  logic [rrs_pkg::TIME_W-1:0] tick;
  int send_idle_pct;
  int recv_idle_pct;
  int rx_hold_cycles;
  int rx_gap_left;
  int stall_cycles;
  int mismatches;
  int results_seen;
  int words_sent;
  int op_seen [4];
  int wakeups;
  int idle_picks;
  int full_admits;
  int kernel_exits;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic logic [rrs_pkg::IDX_W-1:0] pick_ready(
      input logic [rrs_pkg::TIME_W-1:0] now);
    int unsigned idx;
    int unsigned p;
    idx = sched_cur + 1;
    if (idx >= rrs_pkg::SLOTS) idx = 1;
    for (int v = 0; v < rrs_pkg::SLOTS; v++) begin
      p = idx % rrs_pkg::SLOTS;
      if (p == 0) p = 1;
      if (sched_status[p] == rrs_pkg::SS_SLEEPING && sched_wake[p] <= now) begin
        sched_status[p] = rrs_pkg::SS_READY;
        wakeups++;
      end
      if (sched_status[p] == rrs_pkg::SS_READY) begin
        sched_cur = rrs_pkg::IDX_W'(p);
        sched_status[p] = rrs_pkg::SS_RUNNING;
        return rrs_pkg::IDX_W'(p);
      end
      idx++;
    end
    idle_picks++;
    return '0;
  endfunction

  function automatic grant_t schedule_op(input logic [rrs_pkg::OP_W-1:0] op,
                                         input logic [rrs_pkg::SLOT_W-1:0] slot,
                                         input logic [rrs_pkg::TIME_W-1:0] now,
                                         input logic [rrs_pkg::TIME_W-1:0] dur);
    grant_t g;
    g.chosen = '0;
    g.status = rrs_pkg::RS_OK;
    case (op)
      rrs_pkg::OP_PICK: begin
        g.chosen = pick_ready(now);
      end
      rrs_pkg::OP_ADMIT: begin
        g.status = rrs_pkg::RS_NO_FREE;
        for (int i = 1; i < rrs_pkg::SLOTS; i++) begin
          if (sched_status[i] == rrs_pkg::SS_UNUSED) begin
            sched_status[i] = rrs_pkg::SS_READY;
            sched_user[i] = 1'b1;
            g.chosen = rrs_pkg::CHOSEN_W'(i);
            g.status = rrs_pkg::RS_OK;
            break;
          end
        end
        if (g.status == rrs_pkg::RS_NO_FREE) full_admits++;
      end
      rrs_pkg::OP_SLEEP: begin
        if (slot < rrs_pkg::SLOTS) begin
          sched_status[slot] = rrs_pkg::SS_SLEEPING;
          sched_wake[slot] = now + dur;
        end
        g.chosen = sched_cur;
      end
      default: begin
        if (sched_user[sched_cur]) begin
          sched_status[sched_cur] = rrs_pkg::SS_UNUSED;
          g.chosen = pick_ready(now);
        end else begin
          g.chosen = sched_cur;
          g.status = rrs_pkg::RS_HALT;
          kernel_exits++;
        end
      end
    endcase
    return g;
  endfunction

  task automatic send_word(input logic [rrs_pkg::OP_W-1:0] op,
                           input logic [rrs_pkg::SLOT_W-1:0] slot,
                           input logic [rrs_pkg::TIME_W-1:0] now,
                           input logic [rrs_pkg::TIME_W-1:0] dur);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.slot     <= slot;
    in_ch.now      <= now;
    in_ch.duration <= dur;
    do @(posedge clk); while (!in_ch.ready);
    grant_q.push_back(schedule_op(op, slot, now, dur));
    words_sent++;
    op_seen[op]++;
  endtask

  task automatic send_random_word();
    logic [rrs_pkg::OP_W-1:0]   op;
    logic [rrs_pkg::SLOT_W-1:0] slot;
    logic [rrs_pkg::TIME_W-1:0] now;
    logic [rrs_pkg::TIME_W-1:0] dur;
    int unsigned                r;
    r = $urandom_range(0, 99);
    if (r < 35) op = rrs_pkg::OP_PICK;
    else if (r < 55) op = rrs_pkg::OP_ADMIT;
    else if (r < 80) op = rrs_pkg::OP_SLEEP;
    else op = rrs_pkg::OP_EXIT;
    tick += $urandom_range(0, 24);
    now = tick;
    dur = $urandom_range(0, 80);
    slot = rrs_pkg::SLOT_W'($urandom_range(1, rrs_pkg::SLOTS - 1));
    if ($urandom_range(0, 15) == 0) slot = rrs_pkg::SLOT_W'($urandom_range(0, rrs_pkg::SLOTS - 1));
    if ($urandom_range(0, 15) == 0) now = $urandom();
    if ($urandom_range(0, 15) == 0) dur = $urandom();
    if (op != rrs_pkg::OP_SLEEP) begin
      slot = rrs_pkg::SLOT_W'($urandom());
      dur = $urandom();
    end
    send_word(op, slot, now, dur);
  endtask

  task automatic test_kernel_mode();
    send_word(rrs_pkg::OP_EXIT, 4'd0, 32'h0000_0000, 32'h0000_0000);
    send_word(rrs_pkg::OP_PICK, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(rrs_pkg::OP_SLEEP, 4'd0, 32'h0000_0000, 32'h0000_0000);
    send_word(rrs_pkg::OP_EXIT, 4'd9, 32'h0000_0001, 32'h8000_0000);
  endtask

  task automatic test_admit_full();
    for (int i = 0; i < rrs_pkg::SLOTS; i++) begin
      send_word(rrs_pkg::OP_ADMIT, rrs_pkg::SLOT_W'(i), $urandom(), $urandom());
    end
  endtask

  task automatic test_sleep_and_wake();
    send_word(rrs_pkg::OP_PICK, 4'd0, 32'h0000_0005, 32'h0000_0000);
    send_word(rrs_pkg::OP_SLEEP, 4'd2, 32'hFFFF_FFF0, 32'h0000_0020);
    send_word(rrs_pkg::OP_SLEEP, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(rrs_pkg::OP_SLEEP, 4'd1, 32'h0000_0000, 32'h0000_0000);
    send_word(rrs_pkg::OP_EXIT, 4'd0, 32'h0000_0008, 32'h0000_0000);
    send_word(rrs_pkg::OP_PICK, 4'd0, 32'h0000_0010, 32'h0000_0000);
    send_word(rrs_pkg::OP_ADMIT, 4'd0, 32'h0000_0010, 32'h0000_0000);
  endtask

  task automatic test_random_mix(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 15;
          default: send_idle_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 15;
          default: recv_idle_pct = 40;
        endcase
      end
      send_random_word();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold_cycles = 200;
    repeat (24) send_random_word();
  endtask

  task automatic test_time_wrap();
    tick = 32'hFFFF_FF00;
    test_random_mix(300);
  endtask

  task automatic test_steady_stream();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (200) send_random_word();
  endtask

  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_cycles--;
    end else if (rx_gap_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_gap_left--;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      out_ch.ready <= 1'b0;
      rx_gap_left = $urandom_range(0, 13);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result word chosen_slot=%0d status=%0d",
                   out_ch.chosen_slot, out_ch.status);
      end else begin
        want = grant_q.pop_front();
        if (out_ch.chosen_slot !== want.chosen || out_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: result %0d expected chosen_slot=%0d status=%0d, got %0d/%0d",
                     results_seen, want.chosen, want.status, out_ch.chosen_slot,
                     out_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, grant_q.size());
      $display("round_robin_sleep_scheduler_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = rrs_pkg::OP_PICK;
    in_ch.slot = '0;
    in_ch.now = '0;
    in_ch.duration = '0;
    out_ch.ready = 1'b0;
    tick = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold_cycles = 0;
    rx_gap_left = 0;
    stall_cycles = 0;
    mismatches = 0;
    results_seen = 0;
    words_sent = 0;
    wakeups = 0;
    idle_picks = 0;
    full_admits = 0;
    kernel_exits = 0;
    for (int i = 0; i < 4; i++) op_seen[i] = 0;
    for (int i = 0; i < rrs_pkg::SLOTS; i++) begin
      sched_status[i] = (i == 0) ? rrs_pkg::SS_RUNNING : rrs_pkg::SS_UNUSED;
      sched_wake[i] = '0;
      sched_user[i] = 1'b0;
    end
    sched_cur = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_kernel_mode();
    test_admit_full();
    test_sleep_and_wake();
    test_random_mix(1400);
    test_backpressure();
    test_time_wrap();
    test_steady_stream();

    in_ch.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (pick %0d, admit %0d, sleep %0d, exit %0d), checked %0d results.",
             words_sent, op_seen[rrs_pkg::OP_PICK], op_seen[rrs_pkg::OP_ADMIT],
             op_seen[rrs_pkg::OP_SLEEP], op_seen[rrs_pkg::OP_EXIT], results_seen);
    $display("Saw %0d wake-ups, %0d idle picks, %0d admits to a full table, %0d halts.",
             wakeups, idle_picks, full_admits, kernel_exits);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("round_robin_sleep_scheduler_tb: PASS");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("round_robin_sleep_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== round_robin_sleep_scheduler.f =====
rtl/rrs_pkg.sv
rtl/rrs_if.sv
rtl/round_robin_sleep_scheduler.sv
rtl/rrs_checker.sv
verif/round_robin_sleep_scheduler_tb.sv
